// File: rtl/bps_pkg.sv
// Package for the battery percent smoother: widths, reset values, register
// indexes, text constants and the percent-to-ASCII formatting function.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bps_pkg;

   // Depth of the sample ring and the field widths.
   localparam int SAMPLES  = 8;
   localparam int MV_W     = 13;
   localparam int PCT_W    = 7;
   localparam int LEN_W    = 3;
   localparam int CHAR_W   = 7;

   // Derived datapath widths.
   localparam int SLOT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int COUNT_W  = $clog2(SAMPLES + 1);
   localparam int SUM_W    = MV_W + COUNT_W;
   localparam int DEN_W    = SUM_W + 1;
   localparam int NUM_W    = SUM_W + 10;
   localparam int REM_W    = DEN_W + 7;
   localparam int QUOT_W   = 7;
   localparam int STEP_W   = 3;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = MV_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMPTY_MV = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_MV  = 1'd1;

   localparam logic [MV_W-1:0] EMPTY_MV_RESET = 13'd3300;
   localparam logic [MV_W-1:0] FULL_MV_RESET  = 13'd4200;

   // Percent codes.
   localparam logic [PCT_W-1:0] PCT_NONE = 7'd127;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
   localparam logic [PCT_W-1:0] PCT_TEN  = 7'd10;

   // ASCII characters used in the text.
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_ONE  = 7'h31;
   localparam logic [CHAR_W-1:0] CHAR_PERCENT    = 7'h25;
   localparam logic [CHAR_W-1:0] CHAR_NONE       = 7'h00;

   localparam logic [LEN_W-1:0] LEN_ONE_DIGIT    = 3'd2;
   localparam logic [LEN_W-1:0] LEN_TWO_DIGITS   = 3'd3;
   localparam logic [LEN_W-1:0] LEN_THREE_DIGITS = 3'd4;

   typedef struct packed {
      logic [LEN_W-1:0]  text_length;
      logic [CHAR_W-1:0] char_first;
      logic [CHAR_W-1:0] char_second;
      logic [CHAR_W-1:0] char_third;
      logic [CHAR_W-1:0] char_fourth;
   } text_type;

   // Turns a percent of 0..100 into its ASCII text with a trailing sign.
   function automatic text_type bps_format(input logic [PCT_W-1:0] pct);
      logic [3:0]       tens;
      logic [PCT_W-1:0] ones;
      text_type         t;
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (pct >= PCT_W'(10 * k)) begin
            tens = 4'(k);
         end
      end
      ones = pct - ({3'd0, tens} * PCT_TEN);
      t = '0;
      if (pct >= PCT_FULL) begin
         t.text_length = LEN_THREE_DIGITS;
         t.char_first  = CHAR_DIGIT_ONE;
         t.char_second = CHAR_DIGIT_ZERO;
         t.char_third  = CHAR_DIGIT_ZERO;
         t.char_fourth = CHAR_PERCENT;
      end else if (pct >= PCT_TEN) begin
         t.text_length = LEN_TWO_DIGITS;
         t.char_first  = CHAR_DIGIT_ZERO + {3'd0, tens};
         t.char_second = CHAR_DIGIT_ZERO + ones;
         t.char_third  = CHAR_PERCENT;
         t.char_fourth = CHAR_NONE;
      end else begin
         t.text_length = LEN_ONE_DIGIT;
         t.char_first  = CHAR_DIGIT_ZERO + ones;
         t.char_second = CHAR_PERCENT;
         t.char_third  = CHAR_NONE;
         t.char_fourth = CHAR_NONE;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bps_channel_if.sv
// Channel interfaces of the battery percent smoother: the sample request
// channel and the percent response channel. Depends on bps_pkg.
`default_nettype none

interface bps_req_if;
   import bps_pkg::*;

   logic            valid;
   logic            ready;
   logic [MV_W-1:0] sample_mv;
   logic            force_req;

   modport source (output valid, output sample_mv, output force_req, input ready);
   modport sink   (input valid, input sample_mv, input force_req, output ready);
endinterface

interface bps_rsp_if;
   import bps_pkg::*;

   logic              valid;
   logic              ready;
   logic [PCT_W-1:0]  percent;
   logic [LEN_W-1:0]  text_length;
   logic [CHAR_W-1:0] char_first;
   logic [CHAR_W-1:0] char_second;
   logic [CHAR_W-1:0] char_third;
   logic [CHAR_W-1:0] char_fourth;

   modport source (output valid, output percent, output text_length, output char_first,
                   output char_second, output char_third, output char_fourth, input ready);
   modport sink   (input valid, input percent, input text_length, input char_first,
                   input char_second, input char_third, input char_fourth, output ready);
endinterface

`default_nettype wire

// File: rtl/battery_percent_smoother_unit.sv
// Top level of the battery percent smoother: sample ring memory, summing
// sweep, scaling, restoring divider and the response register.
// Depends on bps_pkg and the channel interfaces in bps_channel_if.
`default_nettype none

// Each request transaction writes one millivolt sample into an eight-entry
// ring memory, then the block sweeps the filled entries through the memory's
// single read port to form their sum, maps the average from empty_mv to
// full_mv onto 0..100 percent (rounded half up, clamped) with a seven-step
// restoring divider, and returns a response transaction with the percent and
// its ASCII text when the percent changed or force_req was set. A sample passes
// through the read sweep over the n filled entries (1..8), then the scaling,
// offset and bounds stages, the divider and the result stage. A result that
// clamps in the bounds stage skips the divider, and a span that is not
// positive also skips the bounds stage.
// A new request is taken once the previous one is finished;
// a finished response waits in its own register and does not hold the
// request side, unless a second response is due before the first is taken.
// No clearing pass follows reset: only entries already written are read.
module battery_percent_smoother_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bps_req_if.sink                              req_chan,
   bps_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [bps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bps_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bps_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SUM    = 7'b0000010,
      ST_SCALE  = 7'b0000100,
      ST_OFFSET = 7'b0001000,
      ST_BOUND  = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   localparam logic signed [NUM_W-1:0] PCT_SCALE_NUM = NUM_W'(200);

   // Control registers.
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PCT_W-1:0]   last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_ff;
   logic [MV_W-1:0]    empty_ff, full_ff;

   // Datapath registers.
   logic [MV_W-1:0]          mem [SAMPLES];
   logic [MV_W-1:0]          rd_data_ff;
   logic [COUNT_W-1:0]       addr_ff;
   logic [SUM_W-1:0]         acc_ff;
   logic                     force_ff;
   logic [SUM_W-1:0]         lo_prod_ff;
   logic [SUM_W-1:0]         span_prod_ff;
   logic                     span_pos_ff;
   logic signed [NUM_W-1:0]  scaled_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [REM_W-1:0]         dsh_ff;
   logic [QUOT_W-1:0]        quot_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [PCT_W-1:0]         pct_ff;
   text_type                 text_ff;
   logic [PCT_W-1:0]         percent_ff;

   // Combinational datapath.
   logic                     req_accept;
   logic                     issue;
   logic [SUM_W-1:0]         count_ext;
   logic [SUM_W-1:0]         empty_ext;
   logic [MV_W-1:0]          span_mv;
   logic signed [SUM_W:0]    diff;
   logic signed [NUM_W-1:0]  diff_ext;
   logic signed [NUM_W-1:0]  num;
   logic signed [NUM_W-1:0]  bound;
   logic [REM_W:0]           trial;
   logic [QUOT_W-1:0]        quot_next;
   logic                     emit;
   logic                     out_free;
   logic                     rsp_load;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign issue          = (addr_ff < count_ff);

   assign count_ext = SUM_W'(count_ff);
   assign empty_ext = SUM_W'(empty_ff);
   assign span_mv   = full_ff - empty_ff;

   assign diff      = $signed({1'b0, acc_ff}) - $signed({1'b0, lo_prod_ff});
   assign diff_ext  = NUM_W'(diff);
   assign num       = scaled_ff + $signed(NUM_W'(span_prod_ff));
   assign bound     = $signed(NUM_W'({den_ff, 7'd0}));

   assign trial     = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign quot_next = {quot_ff[QUOT_W-2:0], ~trial[REM_W]};

   assign emit      = force_ff || (pct_ff != last_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load  = (state_ff == ST_DONE) && emit && out_free;

   // Sequencer for one sample.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!issue && !pend_ff) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            state_in = span_pos_ff ? ST_BOUND : ST_DONE;
         end
         ST_BOUND: begin
            if (num <= 0 || num >= bound) state_in = ST_DONE;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!emit || out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Ring pointer, fill count, last emitted percent and response valid.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (req_accept) begin
         slot_in = (slot_ff == SLOT_W'(SAMPLES - 1)) ? '0 : slot_ff + 1'b1;
         if (count_ff < COUNT_W'(SAMPLES)) count_in = count_ff + 1'b1;
      end
      last_in      = rsp_load ? pct_ff : last_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= PCT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= EMPTY_MV_RESET;
         full_ff  <= FULL_MV_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EMPTY_MV: empty_ff <= csr_write_data;
            CSR_FULL_MV:  full_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sample memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (req_accept) mem[slot_ff] <= req_chan.sample_mv;
      rd_data_ff <= mem[addr_ff[SLOT_W-1:0]];
   end

   // Read sweep marker: the read issued last cycle has data this cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (state_ff == ST_SUM) begin
         pend_ff <= issue;
      end else begin
         pend_ff <= 1'b0;
      end
   end

   // Arithmetic datapath, one stage per state.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               force_ff <= req_chan.force_req;
               addr_ff  <= '0;
               acc_ff   <= '0;
            end
         end
         ST_SUM: begin
            if (issue) addr_ff <= addr_ff + 1'b1;
            if (pend_ff) acc_ff <= acc_ff + SUM_W'(rd_data_ff);
         end
         ST_SCALE: begin
            // Count times the empty level, and count times the span.
            lo_prod_ff   <= count_ext * empty_ext;
            span_prod_ff <= count_ext * SUM_W'(span_mv);
            span_pos_ff  <= (full_ff > empty_ff);
         end
         ST_OFFSET: begin
            // With no positive span the percent is all or nothing.
            pct_ff    <= (diff >= 0) ? PCT_FULL : PCT_ZERO;
            scaled_ff <= diff_ext * PCT_SCALE_NUM;
            den_ff    <= {span_prod_ff, 1'b0};
         end
         ST_BOUND: begin
            // Values at or below zero clamp low; quotients of 128 or more clamp high.
            if (num <= 0) begin
               pct_ff <= PCT_ZERO;
            end else if (num >= bound) begin
               pct_ff <= PCT_FULL;
            end
            rem_ff  <= REM_W'(num);
            dsh_ff  <= REM_W'({den_ff, 6'd0});
            step_ff <= STEP_W'(QUOT_W - 1);
            quot_ff <= '0;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle, MSB first.
            if (!trial[REM_W]) rem_ff <= trial[REM_W-1:0];
            dsh_ff  <= dsh_ff >> 1;
            quot_ff <= quot_next;
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               pct_ff <= (quot_next > PCT_FULL) ? PCT_FULL : quot_next;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               percent_ff <= pct_ff;
               text_ff    <= bps_format(pct_ff);
            end
         end
         default: ;
      endcase
   end

   // Response channel.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.percent     = percent_ff;
   assign rsp_chan.text_length = text_ff.text_length;
   assign rsp_chan.char_first  = text_ff.char_first;
   assign rsp_chan.char_second = text_ff.char_second;
   assign rsp_chan.char_third  = text_ff.char_third;
   assign rsp_chan.char_fourth = text_ff.char_fourth;

endmodule

`default_nettype wire

// File: rtl/bps_checker.sv
// Port-level checks for the battery percent smoother, and the bind that
// attaches them to battery_percent_smoother_unit. Depends on bps_pkg.
`default_nettype none

module bps_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [bps_pkg::PCT_W-1:0]  rsp_percent,
   input wire logic [bps_pkg::LEN_W-1:0]  rsp_text_length,
   input wire logic [bps_pkg::CHAR_W-1:0] rsp_char_fourth
);
   import bps_pkg::*;

   // A response never appears in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response stays offered with the same percent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_percent))
      else $error("stalled response transaction changed or vanished");

   // The percent is clamped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_percent <= PCT_FULL)
      else $error("percent above one hundred");

   // Text length follows the number of digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_percent == PCT_FULL && rsp_text_length == LEN_THREE_DIGITS) ||
         (rsp_percent >= PCT_TEN && rsp_percent < PCT_FULL &&
          rsp_text_length == LEN_TWO_DIGITS) ||
         (rsp_percent < PCT_TEN && rsp_text_length == LEN_ONE_DIGIT))
      else $error("text length does not match percent");

   // The fourth character is only used by the full text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_length != LEN_THREE_DIGITS |-> rsp_char_fourth == CHAR_NONE)
      else $error("unused fourth character is not zero");

endmodule

bind battery_percent_smoother_unit bps_checker u_bps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_percent     (rsp_chan.percent),
   .rsp_text_length (rsp_chan.text_length),
   .rsp_char_fourth (rsp_chan.char_fourth)
);

`default_nettype wire
